FILE: design/two_wire_sensor_bus_master_top_defines.svh
// Assertion macros shared by the two-wire sensor bus master checkers.
`ifndef TWO_WIRE_SENSOR_BUS_MASTER_TOP_DEFINES_SVH
`define TWO_WIRE_SENSOR_BUS_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, skipped while reset is high.
`define TWS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define TWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tws_pkg.sv
// Types and constants of the two-wire sensor bus master.
package tws_pkg;

  localparam int PHASE_W = 5;
  localparam int COUNT_W = 4;

  // Operation codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_SEND     = 3'd2;
  localparam logic [2:0] OP_RECEIVE  = 3'd3;
  localparam logic [2:0] OP_CONN_RST = 3'd4;

  // Status codes
  localparam logic [1:0] STATUS_IDLE  = 2'd0;
  localparam logic [1:0] STATUS_BUSY  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // Sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE       = 5'd0;
  localparam logic [PHASE_W-1:0] PH_ST_CLK1    = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ST_PULL    = 5'd2;
  localparam logic [PHASE_W-1:0] PH_ST_LCLK0   = 5'd3;
  localparam logic [PHASE_W-1:0] PH_ST_LCLK1   = 5'd4;
  localparam logic [PHASE_W-1:0] PH_ST_REL     = 5'd5;
  localparam logic [PHASE_W-1:0] PH_ST_CLK0    = 5'd6;
  localparam logic [PHASE_W-1:0] PH_FINISH     = 5'd7;
  localparam logic [PHASE_W-1:0] PH_TX_BIT     = 5'd8;
  localparam logic [PHASE_W-1:0] PH_TX_CLK1    = 5'd9;
  localparam logic [PHASE_W-1:0] PH_TX_CLK0    = 5'd10;
  localparam logic [PHASE_W-1:0] PH_TX_ACKREL  = 5'd11;
  localparam logic [PHASE_W-1:0] PH_TX_ACKCLK1 = 5'd12;
  localparam logic [PHASE_W-1:0] PH_TX_ACKCLK0 = 5'd13;
  localparam logic [PHASE_W-1:0] PH_TX_WAIT    = 5'd14;
  localparam logic [PHASE_W-1:0] PH_RX_BIT     = 5'd15;
  localparam logic [PHASE_W-1:0] PH_RX_CLK1    = 5'd16;
  localparam logic [PHASE_W-1:0] PH_RX_CLK0    = 5'd17;
  localparam logic [PHASE_W-1:0] PH_RX_ACK     = 5'd18;
  localparam logic [PHASE_W-1:0] PH_RX_ACKCLK1 = 5'd19;
  localparam logic [PHASE_W-1:0] PH_RX_ACKCLK0 = 5'd20;
  localparam logic [PHASE_W-1:0] PH_RX_ACKREL  = 5'd21;
  localparam logic [PHASE_W-1:0] PH_RST_CLK1   = 5'd22;
  localparam logic [PHASE_W-1:0] PH_RST_CLK0   = 5'd23;
  localparam logic [PHASE_W-1:0] PH_ERROR      = 5'd24;

  localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       with_ack;
    logic       data_in;
  } in_t;

  typedef struct packed {
    logic       clock_level;
    logic       data_pull_low;
    logic [1:0] status;
    logic [7:0] received_byte;
  } out_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [7:0]         shift_byte;
    logic [COUNT_W-1:0] bit_count;
    logic               ack_wanted;
    logic               clock_line;
    logic               data_line_pulled;
  } seq_state_t;

endpackage

FILE: design/tws_step.sv
// Next-state and result logic for one bus-master transaction.
module tws_step
  import tws_pkg::*;
#(
  parameter int RESET_PULSES = 12
) (
  input  seq_state_t st,
  input  in_t        item,
  output seq_state_t st_next,
  output out_t       result
);

  localparam logic [COUNT_W-1:0] PULSE_LIMIT = COUNT_W'(RESET_PULSES);

  logic [COUNT_W-1:0] count_inc;
  logic [7:0]         rx_mask;

  assign count_inc = st.bit_count + COUNT_W'(1);
  assign rx_mask   = 8'h80 >> st.bit_count[2:0];

  always_comb begin
    st_next = st;
    unique case (item.operation)
      OP_TICK: begin
        unique case (st.phase)
          PH_ST_CLK1: begin
            st_next.clock_line = 1'b1;
            st_next.phase      = PH_ST_PULL;
          end
          PH_ST_PULL: begin
            st_next.data_line_pulled = 1'b1;
            st_next.phase            = PH_ST_LCLK0;
          end
          PH_ST_LCLK0: begin
            st_next.clock_line = 1'b0;
            st_next.phase      = PH_ST_LCLK1;
          end
          PH_ST_LCLK1: begin
            st_next.clock_line = 1'b1;
            st_next.phase      = PH_ST_REL;
          end
          PH_ST_REL: begin
            st_next.data_line_pulled = 1'b0;
            st_next.phase            = PH_ST_CLK0;
          end
          PH_ST_CLK0: begin
            st_next.clock_line = 1'b0;
            st_next.phase      = PH_FINISH;
          end
          PH_FINISH: begin
            st_next.phase = PH_IDLE;
          end
          PH_TX_BIT: begin
            st_next.data_line_pulled = ~st.shift_byte[7];
            st_next.shift_byte       = {st.shift_byte[6:0], 1'b0};
            st_next.phase            = PH_TX_CLK1;
          end
          PH_TX_CLK1: begin
            st_next.clock_line = 1'b1;
            st_next.phase      = PH_TX_CLK0;
          end
          PH_TX_CLK0: begin
            st_next.clock_line = 1'b0;
            st_next.bit_count  = count_inc;
            st_next.phase      = (count_inc < BITS_PER_BYTE) ? PH_TX_BIT : PH_TX_ACKREL;
          end
          PH_TX_ACKREL: begin
            st_next.data_line_pulled = 1'b0;
            st_next.phase            = PH_TX_ACKCLK1;
          end
          PH_TX_ACKCLK1: begin
            st_next.clock_line = 1'b1;
            st_next.phase      = PH_TX_ACKCLK0;
          end
          PH_TX_ACKCLK0: begin
            st_next.clock_line = 1'b0;
            st_next.phase      = item.data_in ? PH_ERROR : PH_TX_WAIT;
          end
          PH_TX_WAIT: begin
            if (!item.data_in) begin
              st_next.phase = PH_FINISH;
            end
          end
          PH_RX_BIT: begin
            st_next.phase = PH_RX_CLK1;
          end
          PH_RX_CLK1: begin
            st_next.clock_line = 1'b1;
            st_next.phase      = PH_RX_CLK0;
          end
          PH_RX_CLK0: begin
            if (item.data_in) begin
              st_next.shift_byte = st.shift_byte | rx_mask;
            end
            st_next.clock_line = 1'b0;
            st_next.bit_count  = count_inc;
            if (count_inc < BITS_PER_BYTE) begin
              st_next.phase = PH_RX_BIT;
            end else if (st.ack_wanted) begin
              st_next.phase = PH_RX_ACK;
            end else begin
              st_next.phase = PH_FINISH;
            end
          end
          PH_RX_ACK: begin
            st_next.data_line_pulled = 1'b1;
            st_next.phase            = PH_RX_ACKCLK1;
          end
          PH_RX_ACKCLK1: begin
            st_next.clock_line = 1'b1;
            st_next.phase      = PH_RX_ACKCLK0;
          end
          PH_RX_ACKCLK0: begin
            st_next.clock_line = 1'b0;
            st_next.phase      = PH_RX_ACKREL;
          end
          PH_RX_ACKREL: begin
            st_next.data_line_pulled = 1'b0;
            st_next.phase            = PH_FINISH;
          end
          PH_RST_CLK1: begin
            st_next.clock_line = 1'b1;
            st_next.phase      = PH_RST_CLK0;
          end
          PH_RST_CLK0: begin
            st_next.clock_line = 1'b0;
            st_next.bit_count  = count_inc;
            st_next.phase      = (count_inc < PULSE_LIMIT) ? PH_RST_CLK1 : PH_FINISH;
          end
          default: begin
            // idle, error and unused codes: hold
          end
        endcase
      end
      OP_START: begin
        st_next.phase = PH_ST_CLK1;
      end
      OP_SEND: begin
        st_next.shift_byte = item.tx_byte;
        st_next.bit_count  = '0;
        st_next.phase      = PH_TX_BIT;
      end
      OP_RECEIVE: begin
        st_next.shift_byte = '0;
        st_next.bit_count  = '0;
        st_next.ack_wanted = item.with_ack;
        st_next.phase      = PH_RX_BIT;
      end
      OP_CONN_RST: begin
        st_next.bit_count        = '0;
        st_next.data_line_pulled = 1'b0;
        st_next.clock_line       = 1'b0;
        st_next.phase            = PH_RST_CLK1;
      end
      default: begin
        // unused operation codes: hold
      end
    endcase
  end

  always_comb begin
    result.clock_level   = st_next.clock_line;
    result.data_pull_low = st_next.data_line_pulled;
    result.received_byte = st_next.shift_byte;
    if (st_next.phase == PH_IDLE) begin
      result.status = STATUS_IDLE;
    end else if (st_next.phase == PH_ERROR) begin
      result.status = STATUS_ERROR;
    end else begin
      result.status = STATUS_BUSY;
    end
  end

endmodule

FILE: design/tws_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
module tws_out_buf
  import tws_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  out_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic main_valid;
  logic skid_valid;
  out_t main_data;
  out_t skid_data;
  logic pop;

  assign pop       = main_valid && out_ready;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!main_valid) begin
        main_valid <= push;
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          main_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || (pop && !skid_valid)) begin
      main_data <= push_data;
    end else if (pop) begin
      main_data <= skid_data;
    end
    if (main_valid && !pop && push) begin
      skid_data <= push_data;
    end
  end

endmodule

FILE: design/two_wire_sensor_bus_master_top.sv
// Top level of the two-wire sensor bus master.
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one transaction per bus
//   phase: a command (start, send byte, receive byte, connection reset) that
//   loads the sequencer, or a tick carrying the sampled data-line level that
//   advances it by one phase.
//   Output channel (out_valid/out_ready/out_data) returns exactly one result
//   per input transaction: clock level, data pull-low, status and the shift
//   register contents.
//   Timing: each result is registered in the result buffer before it is presented.
//   Throughput: one transaction per cycle while in_ready is high; the
//   sequencer state update is a single short step from the state register
//   to itself. Stalls: results sit in a two-entry buffer. With the receiver
//   stalled the block still takes one more transaction; in_ready drops only
//   when both entries hold results.
//   Reset (rst, synchronous): sequencer idle, shift register and bit counter
//   cleared, clock low, data released, both buffer entries empty.
//   A command may arrive at any time, aborting the sequence in progress;
//   it is the only way out of the error status.
module two_wire_sensor_bus_master_top
  import tws_pkg::*;
#(
  parameter int RESET_PULSES = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  seq_state_t st;
  seq_state_t st_next;
  out_t       result;
  logic       buf_full;
  logic       accept;

  // Take a new transaction whenever the result buffer has a free entry.
  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  tws_step #(
    .RESET_PULSES(RESET_PULSES)
  ) u_step (
    .st      (st),
    .item    (in_data),
    .st_next (st_next),
    .result  (result)
  );

  // Advance the sequencer only on an accepted transaction; hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase            <= PH_IDLE;
      st.shift_byte       <= '0;
      st.bit_count        <= '0;
      st.ack_wanted       <= 1'b0;
      st.clock_line       <= 1'b0;
      st.data_line_pulled <= 1'b0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  tws_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/tws_checker.sv
// Port-level checker for the two-wire sensor bus master, with its bind.
`include "two_wire_sensor_bus_master_top_defines.svh"

module tws_checker
  import tws_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `TWS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(out_data), "stalled result changed")
  `TWS_ASSERT_SAME(a_full_has_result, clk, rst, !in_ready, out_valid,
                   "input stalled with no result waiting")
  `TWS_ASSERT_SAME(a_idle_clock_low, clk, rst,
                   out_valid && out_data.status == STATUS_IDLE,
                   !out_data.clock_level, "clock high while idle")
  `TWS_ASSERT_SAME(a_error_lines_released, clk, rst,
                   out_valid && out_data.status == STATUS_ERROR,
                   !out_data.clock_level && !out_data.data_pull_low,
                   "lines driven in error")
  `TWS_ASSERT_SAME(a_status_code, clk, rst, out_valid, out_data.status != 2'd3,
                   "undefined status code")

endmodule

bind two_wire_sensor_bus_master_top tws_checker u_tws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: bench/tb_top.sv
// Self-checking testbench for the two-wire sensor bus master top level.
module tb_top;
  import tws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_PULSES = 12;
  // Stop launching new random sequences once this many transactions went in
  localparam int TARGET_ITEMS = 1450;
  // The remaining operation codes mean nothing to the sequencer
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int STALL_PERCENT = 15;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int IN_W = $bits(in_t);

  // Sequence kinds drawn by the random test
  typedef enum int {SEQ_START, SEQ_SEND, SEQ_RECEIVE, SEQ_CONN_RST} seq_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  two_wire_sensor_bus_master_top #(
    .RESET_PULSES(RESET_PULSES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bus model state, advanced once per accepted transaction
  logic [PHASE_W-1:0] bus_phase;
  logic [7:0]         bus_shift;
  logic [COUNT_W-1:0] bus_count;
  logic               bus_ack_wanted;
  logic               bus_clock;
  logic               bus_data_pulled;

  out_t expected_line_states[$];

  int items_sent;
  int results_checked;
  int error_results;
  int mismatches;
  int commands_seen[8];
  // Set while the run holds both sides busy with no idle cycles at all
  bit no_stall;
  // Ticks still allowed in the current sequence; a small value breaks it off early
  int tick_budget = 1_000_000;

  // Advance the bus model by one phase on a tick
  task automatic advance_bus_phase(input logic din);
    case (bus_phase)
      PH_ST_CLK1: begin
        bus_clock = 1'b1;
        bus_phase = PH_ST_PULL;
      end
      PH_ST_PULL: begin
        bus_data_pulled = 1'b1;
        bus_phase = PH_ST_LCLK0;
      end
      PH_ST_LCLK0: begin
        bus_clock = 1'b0;
        bus_phase = PH_ST_LCLK1;
      end
      PH_ST_LCLK1: begin
        bus_clock = 1'b1;
        bus_phase = PH_ST_REL;
      end
      PH_ST_REL: begin
        bus_data_pulled = 1'b0;
        bus_phase = PH_ST_CLK0;
      end
      PH_ST_CLK0: begin
        bus_clock = 1'b0;
        bus_phase = PH_FINISH;
      end
      PH_FINISH: bus_phase = PH_IDLE;
      PH_TX_BIT: begin
        // A zero bit pulls the line, a one releases it
        bus_data_pulled = ~bus_shift[7];
        bus_shift = {bus_shift[6:0], 1'b0};
        bus_phase = PH_TX_CLK1;
      end
      PH_TX_CLK1: begin
        bus_clock = 1'b1;
        bus_phase = PH_TX_CLK0;
      end
      PH_TX_CLK0: begin
        bus_clock = 1'b0;
        bus_count = bus_count + 1'b1;
        bus_phase = (bus_count < BITS_PER_BYTE) ? PH_TX_BIT : PH_TX_ACKREL;
      end
      PH_TX_ACKREL: begin
        bus_data_pulled = 1'b0;
        bus_phase = PH_TX_ACKCLK1;
      end
      PH_TX_ACKCLK1: begin
        bus_clock = 1'b1;
        bus_phase = PH_TX_ACKCLK0;
      end
      PH_TX_ACKCLK0: begin
        // Sensor must hold the line low to acknowledge
        bus_clock = 1'b0;
        bus_phase = din ? PH_ERROR : PH_TX_WAIT;
      end
      PH_TX_WAIT: begin
        if (!din) begin
          bus_phase = PH_FINISH;
        end
      end
      PH_RX_BIT: bus_phase = PH_RX_CLK1;
      PH_RX_CLK1: begin
        bus_clock = 1'b1;
        bus_phase = PH_RX_CLK0;
      end
      PH_RX_CLK0: begin
        if (din) begin
          bus_shift = bus_shift | (8'h80 >> bus_count[2:0]);
        end
        bus_clock = 1'b0;
        bus_count = bus_count + 1'b1;
        if (bus_count < BITS_PER_BYTE) begin
          bus_phase = PH_RX_BIT;
        end else if (bus_ack_wanted) begin
          bus_phase = PH_RX_ACK;
        end else begin
          bus_phase = PH_FINISH;
        end
      end
      PH_RX_ACK: begin
        bus_data_pulled = 1'b1;
        bus_phase = PH_RX_ACKCLK1;
      end
      PH_RX_ACKCLK1: begin
        bus_clock = 1'b1;
        bus_phase = PH_RX_ACKCLK0;
      end
      PH_RX_ACKCLK0: begin
        bus_clock = 1'b0;
        bus_phase = PH_RX_ACKREL;
      end
      PH_RX_ACKREL: begin
        bus_data_pulled = 1'b0;
        bus_phase = PH_FINISH;
      end
      PH_RST_CLK1: begin
        bus_clock = 1'b1;
        bus_phase = PH_RST_CLK0;
      end
      PH_RST_CLK0: begin
        bus_clock = 1'b0;
        bus_count = bus_count + 1'b1;
        bus_phase = (int'(bus_count) < RESET_PULSES) ? PH_RST_CLK1 : PH_FINISH;
      end
      default: begin
      end
    endcase
  endtask

  // Apply one transaction to the bus model and return the line state it leaves
  task automatic model_bus_step(input in_t item, output out_t res);
    case (item.operation)
      OP_TICK: advance_bus_phase(item.data_in);
      OP_START: bus_phase = PH_ST_CLK1;
      OP_SEND: begin
        bus_shift = item.tx_byte;
        bus_count = '0;
        bus_phase = PH_TX_BIT;
      end
      OP_RECEIVE: begin
        bus_shift = '0;
        bus_count = '0;
        bus_ack_wanted = item.with_ack;
        bus_phase = PH_RX_BIT;
      end
      OP_CONN_RST: begin
        bus_count = '0;
        bus_data_pulled = 1'b0;
        bus_clock = 1'b0;
        bus_phase = PH_RST_CLK1;
      end
      default: begin
      end
    endcase
    res.clock_level   = bus_clock;
    res.data_pull_low = bus_data_pulled;
    if (bus_phase == PH_IDLE) begin
      res.status = STATUS_IDLE;
    end else if (bus_phase == PH_ERROR) begin
      res.status = STATUS_ERROR;
    end else begin
      res.status = STATUS_BUSY;
    end
    res.received_byte = bus_shift;
  endtask

  task automatic report_mismatch(input string field, input int exp_val, input int got_val);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("%0t: %s mismatch on result %0d: expected %0h, got %0h",
               $realtime, field, results_checked, exp_val, got_val);
    end
  endtask

  // Predict on each accepted input, check each accepted result
  always @(posedge clk) begin
    out_t predicted;
    out_t wanted;
    if (!rst) begin
      if (in_valid && in_ready) begin
        model_bus_step(in_data, predicted);
        expected_line_states.push_back(predicted);
        commands_seen[in_data.operation]++;
      end
      if (out_valid && out_ready) begin
        if (expected_line_states.size() == 0) begin
          report_mismatch("unexpected result", 0, out_data);
        end else begin
          wanted = expected_line_states.pop_front();
          if (out_data.clock_level !== wanted.clock_level) begin
            report_mismatch("clock_level", wanted.clock_level, out_data.clock_level);
          end
          if (out_data.data_pull_low !== wanted.data_pull_low) begin
            report_mismatch("data_pull_low", wanted.data_pull_low, out_data.data_pull_low);
          end
          if (out_data.status !== wanted.status) begin
            report_mismatch("status", wanted.status, out_data.status);
          end
          if (out_data.received_byte !== wanted.received_byte) begin
            report_mismatch("received_byte", wanted.received_byte, out_data.received_byte);
          end
          if (wanted.status == STATUS_ERROR) begin
            error_results++;
          end
        end
        results_checked++;
      end
    end
  end

  // Receiver: stall now and then unless the no-idle stretch is running
  always @(posedge clk) begin
    out_ready <= no_stall || ($urandom_range(0, 99) >= STALL_PERCENT);
  end

  // Drive one transaction and hold it until the block takes it
  task automatic push_transaction(input in_t item);
    if (!no_stall && $urandom_range(0, 99) < STALL_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // One tick with the given data-line level unless the budget is spent; other fields carry junk
  task automatic bus_tick(input logic din);
    in_t item;
    if (tick_budget == 0) begin
      return;
    end
    tick_budget--;
    item.operation = OP_TICK;
    item.tx_byte   = 8'($urandom);
    item.with_ack  = 1'($urandom);
    item.data_in   = din;
    push_transaction(item);
  endtask

  task automatic bus_command(input logic [2:0] op, input logic [7:0] value,
                             input logic ack);
    in_t item;
    item.operation = op;
    item.tx_byte   = value;
    item.with_ack  = ack;
    item.data_in   = 1'($urandom);
    push_transaction(item);
  endtask

  task automatic random_ticks(input int count);
    repeat (count) bus_tick(1'($urandom));
  endtask

  // Start pattern: seven phases back to idle
  task automatic run_start_sequence();
    bus_command(OP_START, 8'($urandom), 1'($urandom));
    random_ticks(7);
  endtask

  // Send a byte; a missing acknowledge leaves the block in error
  task automatic run_send_sequence(input logic [7:0] value, input bit acked,
                                   input int busy_ticks);
    bus_command(OP_SEND, value, 1'($urandom));
    random_ticks(3 * 8 + 2);
    bus_tick(!acked);
    if (acked) begin
      // Sensor keeps the line high while measuring, then pulls it low
      repeat (busy_ticks) bus_tick(1'b1);
      bus_tick(1'b0);
      random_ticks(1);
    end else begin
      random_ticks($urandom_range(0, 2));
    end
  endtask

  task automatic run_receive_sequence(input logic ack);
    bus_command(OP_RECEIVE, 8'($urandom), ack);
    random_ticks(3 * 8 + (ack ? 4 : 0) + 1);
  endtask

  task automatic run_conn_reset_sequence();
    bus_command(OP_CONN_RST, 8'($urandom), 1'($urandom));
    random_ticks(2 * RESET_PULSES + 1);
  endtask

  task automatic run_random_sequence();
    seq_kind_t kind;
    kind = seq_kind_t'($urandom_range(0, 3));
    case (kind)
      SEQ_START:    run_start_sequence();
      SEQ_SEND:     run_send_sequence(8'($urandom), $urandom_range(0, 99) < 80,
                                      $urandom_range(0, 3));
      SEQ_RECEIVE:  run_receive_sequence(1'($urandom));
      SEQ_CONN_RST: run_conn_reset_sequence();
      default: begin
      end
    endcase
  endtask

  // Corners: junk fields, spare codes, ticks while idle, aborts of every sequence
  task automatic test_command_corners();
    bus_tick(1'b1);
    bus_command(OP_SPARE_FIRST, 8'hFF, 1'b1);
    bus_command(OP_SPARE_LAST, 8'h00, 1'b0);
    bus_command(OP_START, 8'h00, 1'b0);
    random_ticks(3);
    // Abort the start pattern with a send of all zeros
    bus_command(OP_SEND, 8'h00, 1'b1);
    random_ticks(3);
    bus_command(OP_SEND, 8'hFF, 1'b0);
    random_ticks(3);
    bus_command(OP_RECEIVE, 8'h00, 1'b1);
    bus_tick(1'b1);
    bus_tick(1'b1);
    // Reset mid-receive keeps the shift register and ack request
    bus_command(OP_CONN_RST, 8'hFF, 1'b1);
    random_ticks(2);
    bus_command(OP_SPARE_MID, 8'hA5, 1'b1);
    bus_tick(1'b0);
    bus_command(OP_START, 8'hFF, 1'b1);
  endtask

  // Complete sequences back to back with both sides never idle
  task automatic test_full_sequences();
    no_stall = 1'b1;
    run_start_sequence();
    run_send_sequence(8'hFF, 1'b1, 0);
    run_send_sequence(8'h00, 1'b1, 3);
    run_send_sequence(8'h5A, 1'b0, 0);
    // Ticks in error go nowhere; only a command gets out
    random_ticks(3);
    run_receive_sequence(1'b1);
    run_receive_sequence(1'b0);
    run_conn_reset_sequence();
    no_stall = 1'b0;
  endtask

  // Mostly well-formed sequences, some broken off early, some raw noise
  task automatic test_random_traffic();
    in_t noise;
    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 99) < 20) begin
          tick_budget = $urandom_range(0, 20);
        end
        run_random_sequence();
        tick_budget = 1_000_000;
      end else begin
        repeat ($urandom_range(1, 5)) begin
          noise = in_t'(IN_W'($urandom));
          push_transaction(noise);
        end
      end
    end
  endtask

  initial begin
    bus_phase       = PH_IDLE;
    bus_shift       = '0;
    bus_count       = '0;
    bus_ack_wanted  = 1'b0;
    bus_clock       = 1'b0;
    bus_data_pulled = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_command_corners();
    test_full_sequences();
    test_random_traffic();

    // Drop valid and drain the results still in flight
    in_valid <= 1'b0;
    while (expected_line_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d transactions: %0d start, %0d send, %0d receive, %0d reset commands",
             items_sent, commands_seen[OP_START], commands_seen[OP_SEND],
             commands_seen[OP_RECEIVE], commands_seen[OP_CONN_RST]);
    $display("Checked %0d results, %0d in error status, %0d mismatches",
             results_checked, error_results, mismatches);
    if (mismatches == 0 && expected_line_states.size() == 0) begin
      $display("** two_wire_sensor_bus_master_top: PASSED **");
    end else begin
      $display("** two_wire_sensor_bus_master_top: FAILED **");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run
  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding", expected_line_states.size());
    $display("** two_wire_sensor_bus_master_top: FAILED **");
    $finish;
  end

endmodule
